// ===== rtl/core/mba_pkg.sv =====
// mba_pkg: shared types, constants and helpers for the mosaic block averager
// no dependencies
package mba_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_BLOCK  = 64;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int POS_W      = $clog2(MAX_HEIGHT);
    localparam int OFS_W      = $clog2(MAX_BLOCK);
    localparam int SUM_W      = 20;
    localparam int AREA_W     = 13;
    localparam int QDEPTH     = 2;
    localparam int QAW        = 1;
    localparam int DIV_STEPS  = 11;
    localparam int STEP_W     = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [7:0]       AVG_MAX = 8'hff;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCK  = 2'd2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_start;
    } t_pixel;

    typedef struct packed {
        logic [7:0]  avg_blue;
        logic [7:0]  avg_green;
        logic [7:0]  avg_red;
        logic [10:0] block_col;
        logic [10:0] block_row;
    } t_result;

    typedef struct packed {
        logic [11:0] width;
        logic [11:0] height;
        logic [6:0]  bsize;
    } t_cfg;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sums;
        logic [ADDR_W-1:0]     col;
        logic [POS_W-1:0]      py;
    } t_job;

    function automatic logic [11:0] clamp_dim(input logic [11:0] v);
        logic [11:0] r;
        if (v == 12'd0) r = 12'd1;
        else if (v > 12'(MAX_WIDTH)) r = 12'(MAX_WIDTH);
        else r = v;
        return r;
    endfunction

    function automatic logic [6:0] clamp_block(input logic [6:0] v);
        logic [6:0] r;
        if (v == 7'd0) r = 7'd1;
        else if (v > 7'(MAX_BLOCK)) r = 7'(MAX_BLOCK);
        else r = v;
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [7:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W-7){1'b0}}, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/core/mba_front.sv =====
// mba_front: position counters and column-sum memory read-modify-write
// depends on mba_pkg
module mba_front import mba_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_pixel i_in_data,
    output logic   o_job_valid,
    input  logic   i_job_ready,
    output t_job   o_job
);

    typedef enum logic [2:0] {
        F_CLEAR = 3'b001,
        F_IDLE  = 3'b010,
        F_RMW   = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;

    logic [3*SUM_W-1:0] mem [MAX_WIDTH];
    logic [3*SUM_W-1:0] r_rdata;
    logic [ADDR_W-1:0]  r_clr;

    logic [POS_W-1:0]  r_px, r_py, r_bx, n_px, n_py, n_bx;
    logic [OFS_W-1:0]  r_ox, r_oy, n_ox, n_oy;
    logic [POS_W-1:0]  c_px, c_py, c_bx;
    logic [OFS_W-1:0]  c_ox, c_oy;

    logic [ADDR_W-1:0] r_idx;
    logic              r_first, r_emit;
    logic [POS_W-1:0]  r_ypos;
    logic [7:0]        r_b, r_g, r_r;

    logic              accept, leave;
    logic [2:0][SUM_W-1:0] old_sums, new_sums;
    logic [7:0]        pix [3];

    assign o_in_ready = (r_state == F_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        if (i_in_data.frame_start) begin
            c_px = '0; c_py = '0; c_bx = '0; c_ox = '0; c_oy = '0;
        end else begin
            c_px = r_px; c_py = r_py; c_bx = r_bx; c_ox = r_ox; c_oy = r_oy;
        end
        n_px = c_px; n_py = c_py; n_bx = c_bx; n_ox = c_ox; n_oy = c_oy;
        if ({1'b0, c_px} + 12'd1 >= i_cfg.width) begin
            n_px = '0;
            n_ox = '0;
            n_bx = '0;
            if ({1'b0, c_py} + 12'd1 >= i_cfg.height) begin
                n_py = '0;
                n_oy = '0;
            end else begin
                n_py = c_py + 1'b1;
                n_oy = ({1'b0, c_oy} + 7'd1 >= i_cfg.bsize) ? '0 : c_oy + 1'b1;
            end
        end else begin
            n_px = c_px + 1'b1;
            if ({1'b0, c_ox} + 7'd1 >= i_cfg.bsize) begin
                n_ox = '0;
                n_bx = c_bx + 1'b1;
            end else begin
                n_ox = c_ox + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0; r_py <= '0; r_bx <= '0; r_ox <= '0; r_oy <= '0;
        end else if (accept) begin
            r_px <= n_px; r_py <= n_py; r_bx <= n_bx; r_ox <= n_ox; r_oy <= n_oy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx   <= c_bx;
            r_first <= (c_ox == '0) && (c_oy == '0);
            r_emit  <= ({1'b0, c_ox} + 7'd1 >= i_cfg.bsize)
                    && ({1'b0, c_oy} + 7'd1 >= i_cfg.bsize)
                    && ({1'b0, c_px} < i_cfg.width)
                    && ({1'b0, c_py} < i_cfg.height);
            r_ypos  <= c_py;
            r_b     <= i_in_data.blue;
            r_g     <= i_in_data.green;
            r_r     <= i_in_data.red;
            r_rdata <= mem[c_bx];
        end
    end

    assign old_sums = r_rdata;
    assign pix[0]   = r_b;
    assign pix[1]   = r_g;
    assign pix[2]   = r_r;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            new_sums[c] = r_first ? {{(SUM_W-8){1'b0}}, pix[c]} : sat_add(old_sums[c], pix[c]);
        end
    end

    assign leave       = (r_state == F_RMW) && (!r_emit || i_job_ready);
    assign o_job_valid = (r_state == F_RMW) && r_emit;
    assign o_job.sums  = new_sums;
    assign o_job.col   = r_idx;
    assign o_job.py    = r_ypos;

    always_ff @(posedge i_clk) begin
        if (r_state == F_CLEAR) begin
            mem[r_clr] <= '0;
        end else if (leave) begin
            mem[r_idx] <= new_sums;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_CLEAR: if (r_clr == ADDR_W'(MAX_WIDTH - 1)) n_state = F_IDLE;
            F_IDLE:  if (accept) n_state = F_RMW;
            F_RMW:   if (leave) n_state = F_IDLE;
            default: n_state = F_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

endmodule

// ===== rtl/core/mba_queue.sv =====
// mba_queue: short request queue between front and back
// depends on mba_pkg
module mba_queue import mba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  t_job             i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output t_job             o_pop_data,
    output logic [QAW:0]     o_level
);

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rp];
    assign o_level      = r_cnt;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== rtl/core/mba_back.sv =====
// mba_back: iterative divider for block averages and row index, output register
// depends on mba_pkg
module mba_back import mba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_job_valid,
    output logic    o_job_ready,
    input  t_job    i_job,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_AREA = 5'b00010,
        B_PREP = 5'b00100,
        B_DIV  = 5'b01000,
        B_DONE = 5'b10000
    } t_bstate;

    localparam int CDV_W = AREA_W + DIV_STEPS - 1;
    localparam int RDV_W = 7 + DIV_STEPS - 1;

    t_bstate r_state, n_state;

    t_job                r_job;
    logic [AREA_W-1:0]   r_area;
    logic [SUM_W-1:0]    r_rem [3];
    logic [DIV_STEPS-1:0] r_q [3];
    logic [2:0]          r_sat;
    logic [CDV_W-1:0]    r_cdvs;
    logic [POS_W-1:0]    r_rrem;
    logic [RDV_W-1:0]    r_rdvs;
    logic [DIV_STEPS-1:0] r_rq;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;
    t_result             r_out;
    logic                load_out;
    logic [7:0]          avg [3];

    assign o_job_ready = (r_state == B_IDLE);
    assign load_out    = (r_state == B_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_job_valid) n_state = B_AREA;
            B_AREA: n_state = B_PREP;
            B_PREP: n_state = B_DIV;
            B_DIV:  if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = B_DONE;
            B_DONE: if (load_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: if (i_job_valid) r_job <= i_job;
            B_AREA: r_area <= {{(AREA_W-7){1'b0}}, i_cfg.bsize}
                            * {{(AREA_W-7){1'b0}}, i_cfg.bsize};
            B_PREP: begin
                for (int c = 0; c < 3; c++) begin
                    r_rem[c] <= r_job.sums[c];
                    r_q[c]   <= '0;
                    r_sat[c] <= {1'b0, r_job.sums[c]} >= {r_area, 8'd0};
                end
                r_cdvs <= {r_area, {(DIV_STEPS-1){1'b0}}};
                r_rrem <= r_job.py;
                r_rdvs <= {i_cfg.bsize, {(DIV_STEPS-1){1'b0}}};
                r_rq   <= '0;
                r_step <= '0;
            end
            B_DIV: begin
                for (int c = 0; c < 3; c++) begin
                    if ({{(CDV_W-SUM_W){1'b0}}, r_rem[c]} >= r_cdvs) begin
                        r_rem[c] <= r_rem[c] - r_cdvs[SUM_W-1:0];
                        r_q[c]   <= {r_q[c][DIV_STEPS-2:0], 1'b1};
                    end else begin
                        r_q[c]   <= {r_q[c][DIV_STEPS-2:0], 1'b0};
                    end
                end
                if ({{(RDV_W-POS_W){1'b0}}, r_rrem} >= r_rdvs) begin
                    r_rrem <= r_rrem - r_rdvs[POS_W-1:0];
                    r_rq   <= {r_rq[DIV_STEPS-2:0], 1'b1};
                end else begin
                    r_rq   <= {r_rq[DIV_STEPS-2:0], 1'b0};
                end
                r_cdvs <= r_cdvs >> 1;
                r_rdvs <= r_rdvs >> 1;
                r_step <= r_step + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            avg[c] = r_sat[c] ? AVG_MAX : r_q[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.avg_blue  <= avg[0];
            r_out.avg_green <= avg[1];
            r_out.avg_red   <= avg[2];
            r_out.block_col <= r_job.col;
            r_out.block_row <= r_rq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/mosaic_block_averager.sv =====
// mosaic_block_averager: top level, configuration registers and front/queue/back
// depends on mba_pkg, mba_front, mba_queue, mba_back
//
//  channel  direction  handshake                      payload
//  in       sink       i_in_valid / o_in_ready        i_in_data  (t_pixel)
//  out      source     o_out_valid / i_out_ready      o_out_data (t_result)
//  cfg      sink       i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  the front takes a pixel only while idle, so it ends the column-sum memory read-modify-write before the next
//  the back takes a finished block through area, prep, an 11-step divide and done states
//  the queue holds 2 blocks so pixels keep flowing while the back divides
//  after reset the front clears every column-sum memory entry before it takes any pixel
//  a full queue holds the front on a block's last pixel; the output register holds results
module mosaic_block_averager import mba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_pixel      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    logic [11:0]  r_width, r_height;
    logic [6:0]   r_bsize;
    t_cfg         cfg;
    logic         w_push_valid, w_push_ready, w_pop_valid, w_pop_ready;
    t_job         w_push_data, w_pop_data;
    logic [QAW:0] w_q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_bsize  <= 7'd50;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_BLOCK:  r_bsize  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign cfg.width  = clamp_dim(r_width);
    assign cfg.height = clamp_dim(r_height);
    assign cfg.bsize  = clamp_block(r_bsize);

    mba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (w_push_valid),
        .i_job_ready (w_push_ready),
        .o_job       (w_push_data)
    );

    mba_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data),
        .o_level      (w_q_level)
    );

    mba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (w_pop_valid),
        .o_job_ready (w_pop_ready),
        .i_job       (w_pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("front took a pixel in back-to-back cycles");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_level <= (QAW+1)'(QDEPTH))
        else $error("queue level beyond depth");

    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid && w_push_ready && !(w_pop_valid && w_pop_ready)
        |=> w_q_level == $past(w_q_level) + 1'b1)
        else $error("queue lost a request");

endmodule
